### rtl/rxah_pkg.sv
package rxah_pkg;

    localparam int unsigned NUM_WORDS   = 4;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned DIGEST_CHARS = 32;
    localparam int unsigned CHAR_CNT_W  = $clog2(DIGEST_CHARS);

    localparam logic [WORD_W-1:0] INIT_W0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] INIT_W1 = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] INIT_W2 = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] INIT_W3 = 32'h1032_5476;

    localparam logic [3:0] NIB_MASK      = 4'hF;
    localparam logic [6:0] ASCII_ZERO    = 7'd48;
    localparam logic [6:0] ASCII_A_MINUS = 7'd55;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       is_final;
    } t_in;

    typedef struct packed {
        logic [6:0] hex_char;
        logic       digest_end;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    function automatic logic [6:0] nibble_to_ascii(input logic [3:0] nib);
        logic [3:0] n;
        n = nib & NIB_MASK;
        if (n < 4'd10) begin
            return ASCII_ZERO + {3'b000, n};
        end
        return ASCII_A_MINUS + {3'b000, n};
    endfunction

endpackage

### rtl/rotate_xor_add_hash_hex.sv
// rotate-xor-add byte hash with a hex digest
//
// input channel (i_in_valid / o_in_ready / i_in_item): one message byte per
// item, with is_final marking the last byte of a message. a byte is mixed
// into one of four 32-bit words (xor, rotate left by phase+1, add) in the
// cycle it is accepted, so non-final bytes go at one per cycle.
//
// output channel (o_out_valid / i_out_ready / o_out_item): after a final
// byte the block emits 32 ascii hex characters, word 0 through word 3,
// least significant nibble first; digest_end marks the last one. the first
// character is valid the cycle after the final byte is taken, then one per
// cycle while i_out_ready is high.
//
// while the digest is being sent o_in_ready is low; a stalled receiver just
// holds the current character. after the last character is taken the words
// and byte phase return to their initial values and input opens again.
// reset (i_rst_n low, synchronous) loads the initial words, clears the
// phase and drops any digest in flight.
module rotate_xor_add_hash_hex
    import rxah_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    t_state                r_state, n_state;
    logic [WORD_W-1:0]     r_words [NUM_WORDS];
    logic [WORD_W-1:0]     n_words [NUM_WORDS];
    logic [1:0]            r_phase, n_phase;
    logic [CHAR_CNT_W-1:0] r_cnt, n_cnt;

    logic              in_fire, out_fire, last_char;
    logic [WORD_W-1:0] mix_x, mix_r, mix_sum;
    logic [WORD_W-1:0] emit_word;
    logic [3:0]        emit_nib;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;
    assign last_char   = (r_cnt == CHAR_CNT_W'(DIGEST_CHARS - 1));

    // shared mixing unit
    always_comb begin
        mix_x = r_words[r_phase] ^ {24'd0, i_in_item.msg_byte};
        unique case (r_phase)
            2'd0:    mix_r = {mix_x[WORD_W-2:0], mix_x[WORD_W-1]};
            2'd1:    mix_r = {mix_x[WORD_W-3:0], mix_x[WORD_W-1 -: 2]};
            2'd2:    mix_r = {mix_x[WORD_W-4:0], mix_x[WORD_W-1 -: 3]};
            default: mix_r = {mix_x[WORD_W-5:0], mix_x[WORD_W-1 -: 4]};
        endcase
        mix_sum = mix_r + {24'd0, i_in_item.msg_byte};
    end

    assign emit_word = r_words[r_cnt[CHAR_CNT_W-1 -: 2]];
    assign emit_nib  = emit_word[{r_cnt[2:0], 2'b00} +: 4];

    assign o_out_item.hex_char   = nibble_to_ascii(emit_nib);
    assign o_out_item.digest_end = last_char;

    always_comb begin
        n_state = r_state;
        n_words = r_words;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_words[r_phase] = mix_sum;
                    n_phase          = r_phase + 2'd1;
                    n_cnt            = '0;
                    if (i_in_item.is_final) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_fire) begin
                    n_cnt = r_cnt + CHAR_CNT_W'(1);
                    if (last_char) begin
                        n_state    = ST_IDLE;
                        n_words[0] = INIT_W0;
                        n_words[1] = INIT_W1;
                        n_words[2] = INIT_W2;
                        n_words[3] = INIT_W3;
                        n_phase    = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_words[0] <= INIT_W0;
            r_words[1] <= INIT_W1;
            r_words[2] <= INIT_W2;
            r_words[3] <= INIT_W3;
            r_phase    <= '0;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;
            r_words <= n_words;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_final_starts_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_item.is_final |=> o_out_valid && (r_cnt == '0))
        else $error("digest did not start at first character");

    a_last_char_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && o_out_item.digest_end |=> o_in_ready && (r_phase == 2'd0)
            && (r_words[0] == INIT_W0) && (r_words[3] == INIT_W3))
        else $error("state not restored after digest");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input open while digest in flight");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(r_cnt))
        else $error("digest advanced under stall");
`endif

endmodule

### tb/tb_rotate_xor_add_hash_hex.sv
module tb_rotate_xor_add_hash_hex
    import rxah_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int RANDOM_ITEMS = 100;

    typedef logic [8*DIGEST_CHARS-1:0] t_digest;

    typedef struct packed {
        t_in     item;
        t_digest given;
    } t_row;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_item = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_item;

    logic [WORD_W-1:0] words [NUM_WORDS];
    logic [1:0]        phase;
    t_out              digest_q[$];
    t_row              script_q[$];
    t_out              due;
    int                mismatches = 0;
    int                chars_taken = 0;
    int                cycles = 0;
    int                send_calm = 0;

    rotate_xor_add_hash_hex DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic void restart_hash();
        words[0] = INIT_W0;
        words[1] = INIT_W1;
        words[2] = INIT_W2;
        words[3] = INIT_W3;
        phase = 2'd0;
    endfunction

    function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return ASCII_ZERO + {3'b000, nib};
        end
        return ASCII_A_MINUS + {3'b000, nib};
    endfunction

    // mix one byte into the words; on a final byte build the digest text
    function automatic logic absorb_byte(input t_in it, output t_digest text);
        logic [WORD_W-1:0] w;
        int n;
        w = words[phase] ^ {24'h0, it.msg_byte};
        n = phase + 1;
        w = (w << n) | (w >> (WORD_W - n));
        words[phase] = w + {24'h0, it.msg_byte};
        phase = phase + 2'd1;
        text = '0;
        if (!it.is_final) begin
            return 1'b0;
        end
        for (int k = 0; k < DIGEST_CHARS; k++) begin
            text[8*DIGEST_CHARS-1-8*k -: 8] = {1'b0, hex_ascii(words[k/8][4*(k%8) +: 4])};
        end
        restart_hash();
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic fin, input t_digest given);
        t_row r;
        r.item.msg_byte = b;
        r.item.is_final = fin;
        r.given = given;
        script_q.push_back(r);
    endfunction

    task automatic feed_byte(input t_in it, input t_digest given);
        int gap;
        t_digest text;
        t_out e;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (absorb_byte(it, text)) begin
            if (given != '0) begin
                text = given;
            end
            for (int k = 0; k < DIGEST_CHARS; k++) begin
                e.hex_char = text[8*DIGEST_CHARS-2-8*k -: 7];
                e.digest_end = (k == DIGEST_CHARS - 1);
                digest_q.push_back(e);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            chars_taken <= chars_taken + 1;
            if (digest_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected item: char %h end %b",
                             o_out_item.hex_char, o_out_item.digest_end);
                end
                mismatches <= mismatches + 1;
            end else begin
                due = digest_q.pop_front();
                if (o_out_item.hex_char !== due.hex_char ||
                        o_out_item.digest_end !== due.digest_end) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected char %h end %b, got char %h end %b",
                                 due.hex_char, due.digest_end,
                                 o_out_item.hex_char, o_out_item.digest_end);
                    end
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // receiver, with one long hold-off once the first digest is through
    initial begin : receiver
        int wait_cycles;
        int calm;
        logic held;
        calm = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && chars_taken >= 40) begin
                wait_cycles = HOLD_OFF_CYCLES;
                held = 1'b1;
            end else begin
                wait_cycles = draw_wait(calm);
            end
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && out_ready));
        end
    end

    initial begin : stimulus
        t_row r;
        t_in it;
        int sent;
        int len;
        restart_hash();

        // single-byte messages straight from the initial words
        add_row(8'h00, 1'b1, "2064A8EC98BADCFEEFCDAB8967452301");
        add_row(8'hFF, 1'b1, "BF84A8EC98BADCFEEFCDAB8967452301");
        // phase wraps past three
        add_row(8'h80, 1'b0, '0);
        add_row(8'h01, 1'b0, '0);
        add_row(8'h7F, 1'b0, '0);
        add_row(8'hFE, 1'b0, '0);
        add_row(8'h55, 1'b1, '0);
        for (int i = 0; i < 8; i++) begin
            add_row((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0, '0);
        end
        add_row(8'hFF, 1'b1, '0);
        for (int i = 0; i < 4; i++) begin
            add_row(8'hFF, 1'b0, '0);
        end
        add_row(8'hFF, 1'b1, '0);
        add_row(8'h01, 1'b1, '0);
        add_row(8'h80, 1'b1, '0);

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_q[i]) begin
            r = script_q[i];
            feed_byte(r.item, r.given);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24)
                                              : $urandom_range(1, 6);
            if (len > RANDOM_ITEMS - sent) begin
                len = RANDOM_ITEMS - sent;
            end
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0: it.msg_byte = 8'h00;
                    1: it.msg_byte = 8'hFF;
                    default: it.msg_byte = 8'($urandom_range(0, 255));
                endcase
                it.is_final = (i == len - 1);
                feed_byte(it, '0);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rxah_pkg.sv
rtl/rotate_xor_add_hash_hex.sv
tb/tb_rotate_xor_add_hash_hex.sv
